// ===== rtl/core/mpsm_pkg.sv =====
`default_nettype none

package mpsm_pkg;

    // Automaton sizing.
    localparam int MAX_NODES       = 1024;
    localparam int MAX_PATTERNS    = 512;
    localparam int MAX_PATTERN_LEN = 64;
    localparam int ALPHABET_SIZE   = 256;
    localparam int RESULT_CAP      = 64;
    localparam int QUEUE_DEPTH     = 2;

    // Derived widths.
    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int CNT_W    = NODE_W + 1;
    localparam int ID_W     = $clog2(MAX_PATTERNS);
    localparam int WORD_W   = $clog2(MAX_PATTERNS + 1);
    localparam int LEN_W    = $clog2(MAX_PATTERN_LEN + 1);
    localparam int SYM_W    = $clog2(ALPHABET_SIZE);
    localparam int CHILD_AW = NODE_W + SYM_W;
    localparam int RUN_W    = $clog2(RESULT_CAP + 1);
    localparam int POS_W    = 32;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Request codes on the input.
    localparam logic [1:0] REQ_PATTERN = 2'd0;
    localparam logic [1:0] REQ_BUILD   = 2'd1;
    localparam logic [1:0] REQ_TEXT    = 2'd2;

    typedef enum logic [1:0] {
        OP_PATTERN,
        OP_BUILD,
        OP_TEXT,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] symbol;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] match_start;
        logic [31:0] match_end;
        logic [8:0]  pattern_id;
        logic        last_of_run;
        logic        overflow_seen;
    } result_t;

    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpsm_front.sv =====
`default_nettype none

module mpsm_front (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire mpsm_pkg::in_item_t     item,
    output logic                        busy,
    input  wire mpsm_pkg::back_status_t back_status,
    output logic                        cmd_valid,
    output mpsm_pkg::cmd_t              cmd
);
    import mpsm_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    cmd_t              cls;

    // The queue is full or the back end is still clearing its tables.
    assign busy      = (count_reg == QCNT_W'(QUEUE_DEPTH)) || back_status.clearing;
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Classify the incoming item.
    always_comb
    begin
        cls.symbol = SYM_W'(item.symbol % ALPHABET_SIZE);
        cls.last   = item.last;
        case (item.req_type)
            REQ_PATTERN: cls.op = OP_PATTERN;
            REQ_BUILD:   cls.op = OP_BUILD;
            REQ_TEXT:    cls.op = OP_TEXT;
            default:     cls.op = OP_NONE;
        endcase
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (back_status.pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !back_status.pop)
            begin
                count_reg <= QCNT_W'(count_reg + 1'b1);
            end
            else if (!push && back_status.pop)
            begin
                count_reg <= QCNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mpsm_back.sv =====
`default_nettype none

module mpsm_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cmd_valid,
    input  wire mpsm_pkg::cmd_t         cmd,
    output mpsm_pkg::back_status_t      status,
    output logic                        result_valid,
    output mpsm_pkg::result_t           result
);
    import mpsm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_B_POP,
        S_B_U,
        S_B_FU,
        S_B_CRD,
        S_B_CV,
        S_B_F,
        S_B_WR,
        S_G_RD,
        S_G_CHK,
        S_T_WALK,
        S_T_W,
        S_T_L
    } state_t;

    // Tables.
    logic [NODE_W-1:0] child_mem [2**CHILD_AW];
    logic [NODE_W-1:0] fail_mem  [MAX_NODES];
    logic [NODE_W-1:0] swl_mem   [MAX_NODES];
    logic [WORD_W-1:0] nword_mem [MAX_NODES];
    logic [LEN_W-1:0]  wlen_mem  [MAX_PATTERNS];
    logic [NODE_W-1:0] bfsq_mem  [MAX_NODES];

    logic [NODE_W-1:0] child_rdata_reg, fail_rdata_reg, swl_rdata_reg, bfsq_rdata_reg;
    logic [WORD_W-1:0] nword_rdata_reg;
    logic [LEN_W-1:0]  wlen_rdata_reg;

    logic                child_we, fail_we, swl_we, nword_we, wlen_we, bfsq_we;
    logic [CHILD_AW-1:0] child_wa, child_ra;
    logic [NODE_W-1:0]   child_wd;
    logic [NODE_W-1:0]   fail_wa, fail_ra, fail_wd;
    logic [NODE_W-1:0]   swl_wa, swl_ra, swl_wd;
    logic [NODE_W-1:0]   nword_wa, nword_ra;
    logic [WORD_W-1:0]   nword_wd;
    logic [ID_W-1:0]     wlen_wa, wlen_ra;
    logic [LEN_W-1:0]    wlen_wd;
    logic [NODE_W-1:0]   bfsq_wa, bfsq_ra, bfsq_wd;

    // Control and working registers.
    state_t              state_reg, state_next;
    logic [CHILD_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]    node_count_reg, node_count_next;
    logic [WORD_W-1:0]   word_count_reg, word_count_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [LEN_W-1:0]    ins_len_reg, ins_len_next;
    logic                discard_reg, discard_next;
    logic                links_valid_reg, links_valid_next;
    logic                overflow_reg, overflow_next;
    logic [NODE_W-1:0]   match_reg, match_next;
    logic [POS_W-1:0]    text_pos_reg, text_pos_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                last_reg, last_next;
    logic [SYM_W-1:0]    csym_reg, csym_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   fu_reg, fu_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [NODE_W-1:0]   gnode_reg, gnode_next;
    logic [NODE_W-1:0]   f_reg, f_next;
    logic                gbuild_reg, gbuild_next;
    logic [NODE_W-1:0]   tnode_reg, tnode_next;
    logic [NODE_W-1:0]   tnext_reg, tnext_next;
    logic [ID_W-1:0]     wid_reg, wid_next;
    logic [RUN_W-1:0]    run_n_reg, run_n_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]    pend_start_reg, pend_start_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    assign status.pop      = (state_reg == S_IDLE) && cmd_valid;
    assign status.clearing = (state_reg == S_CLEAR);
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

    // Table write and registered read ports.
    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_wa] <= child_wd;
        end
        child_rdata_reg <= child_mem[child_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_wa] <= fail_wd;
        end
        fail_rdata_reg <= fail_mem[fail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (swl_we)
        begin
            swl_mem[swl_wa] <= swl_wd;
        end
        swl_rdata_reg <= swl_mem[swl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nword_we)
        begin
            nword_mem[nword_wa] <= nword_wd;
        end
        nword_rdata_reg <= nword_mem[nword_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wlen_we)
        begin
            wlen_mem[wlen_wa] <= wlen_wd;
        end
        wlen_rdata_reg <= wlen_mem[wlen_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bfsq_we)
        begin
            bfsq_mem[bfsq_wa] <= bfsq_wd;
        end
        bfsq_rdata_reg <= bfsq_mem[bfsq_ra];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        logic [NODE_W-1:0] nxt;
        logic [WORD_W-1:0] w_minus;
        logic              next_sym;

        nxt      = '0;
        w_minus  = '0;
        next_sym = 1'b0;

        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        node_count_next   = node_count_reg;
        word_count_next   = word_count_reg;
        cursor_next       = cursor_reg;
        ins_len_next      = ins_len_reg;
        discard_next      = discard_reg;
        links_valid_next  = links_valid_reg;
        overflow_next     = overflow_reg;
        match_next        = match_reg;
        text_pos_next     = text_pos_reg;
        pos_next          = pos_reg;
        last_next         = last_reg;
        csym_next         = csym_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        u_next            = u_reg;
        fu_next           = fu_reg;
        v_next            = v_reg;
        gnode_next        = gnode_reg;
        f_next            = f_reg;
        gbuild_next       = gbuild_reg;
        tnode_next        = tnode_reg;
        tnext_next        = tnext_reg;
        wid_next          = wid_reg;
        run_n_next        = run_n_reg;
        pend_valid_next   = pend_valid_reg;
        pend_start_next   = pend_start_reg;
        pend_id_next      = pend_id_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        child_we = 1'b0; child_wa = '0; child_wd = '0; child_ra = '0;
        fail_we  = 1'b0; fail_wa  = '0; fail_wd  = '0; fail_ra  = '0;
        swl_we   = 1'b0; swl_wa   = '0; swl_wd   = '0; swl_ra   = '0;
        nword_we = 1'b0; nword_wa = '0; nword_wd = '0; nword_ra = '0;
        wlen_we  = 1'b0; wlen_wa  = '0; wlen_wd  = '0; wlen_ra  = '0;
        bfsq_we  = 1'b0; bfsq_wa  = '0; bfsq_wd  = '0; bfsq_ra  = '0;

        case (state_reg)
            // Sweep the child table and the word marks after reset.
            S_CLEAR:
            begin
                child_we = 1'b1;
                child_wa = clr_addr_reg;
                if (clr_addr_reg[CHILD_AW-1:NODE_W] == '0)
                begin
                    nword_we = 1'b1;
                    nword_wa = clr_addr_reg[NODE_W-1:0];
                end
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = CHILD_AW'(clr_addr_reg + 1'b1);
                end
            end

            // Take the next command and dispatch it.
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    last_next = cmd.last;
                    csym_next = cmd.symbol;
                    case (cmd.op)
                        OP_PATTERN:
                        begin
                            links_valid_next = 1'b0;
                            if (discard_reg)
                            begin
                                if (cmd.last)
                                begin
                                    discard_next = 1'b0;
                                    cursor_next  = '0;
                                    ins_len_next = '0;
                                end
                            end
                            else if (ins_len_reg >= LEN_W'(MAX_PATTERN_LEN))
                            begin
                                overflow_next = 1'b1;
                                if (cmd.last)
                                begin
                                    discard_next = 1'b0;
                                    cursor_next  = '0;
                                    ins_len_next = '0;
                                end
                                else
                                begin
                                    discard_next = 1'b1;
                                end
                            end
                            else
                            begin
                                child_ra   = {cursor_reg, cmd.symbol};
                                state_next = S_INS_CHK;
                            end
                        end
                        OP_BUILD:
                        begin
                            bfsq_we    = 1'b1;
                            fail_we    = 1'b1;
                            swl_we     = 1'b1;
                            head_next  = '0;
                            tail_next  = CNT_W'(1);
                            state_next = S_B_POP;
                        end
                        OP_TEXT:
                        begin
                            pos_next      = text_pos_reg;
                            text_pos_next = cmd.last ? '0 : POS_W'(text_pos_reg + 1'b1);
                            if (!links_valid_reg)
                            begin
                                match_next = '0;
                            end
                            else
                            begin
                                gnode_next  = match_reg;
                                gbuild_next = 1'b0;
                                state_next  = S_G_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Follow or create the child, and close the word on its last byte.
            S_INS_CHK:
            begin
                state_next = S_IDLE;
                if ((child_rdata_reg == '0) && (node_count_reg >= CNT_W'(MAX_NODES)))
                begin
                    overflow_next = 1'b1;
                    if (last_reg)
                    begin
                        discard_next = 1'b0;
                        cursor_next  = '0;
                        ins_len_next = '0;
                    end
                    else
                    begin
                        discard_next = 1'b1;
                    end
                end
                else
                begin
                    nxt = child_rdata_reg;
                    if (child_rdata_reg == '0)
                    begin
                        nxt             = node_count_reg[NODE_W-1:0];
                        child_we        = 1'b1;
                        child_wa        = {cursor_reg, csym_reg};
                        child_wd        = nxt;
                        node_count_next = CNT_W'(node_count_reg + 1'b1);
                    end
                    cursor_next  = nxt;
                    ins_len_next = LEN_W'(ins_len_reg + 1'b1);
                    if (last_reg)
                    begin
                        cursor_next  = '0;
                        ins_len_next = '0;
                        if (word_count_reg >= WORD_W'(MAX_PATTERNS))
                        begin
                            overflow_next = 1'b1;
                            discard_next  = 1'b0;
                        end
                        else
                        begin
                            nword_we        = 1'b1;
                            nword_wa        = nxt;
                            nword_wd        = WORD_W'(word_count_reg + 1'b1);
                            wlen_we         = 1'b1;
                            wlen_wa         = word_count_reg[ID_W-1:0];
                            wlen_wd         = LEN_W'(ins_len_reg + 1'b1);
                            word_count_next = WORD_W'(word_count_reg + 1'b1);
                        end
                    end
                end
            end

            // Breadth-first walk: take the next node from the queue.
            S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    bfsq_ra    = head_reg[NODE_W-1:0];
                    head_next  = CNT_W'(head_reg + 1'b1);
                    state_next = S_B_U;
                end
                else
                begin
                    links_valid_next = 1'b1;
                    match_next       = '0;
                    state_next       = S_IDLE;
                end
            end

            S_B_U:
            begin
                u_next     = bfsq_rdata_reg;
                fail_ra    = bfsq_rdata_reg;
                state_next = S_B_FU;
            end

            S_B_FU:
            begin
                fu_next    = fail_rdata_reg;
                csym_next  = '0;
                state_next = S_B_CRD;
            end

            S_B_CRD:
            begin
                child_ra   = {u_reg, csym_reg};
                state_next = S_B_CV;
            end

            // Enqueue a present child and find its failure target.
            S_B_CV:
            begin
                if ((child_rdata_reg == '0) || (tail_reg >= CNT_W'(MAX_NODES)))
                begin
                    next_sym = 1'b1;
                end
                else
                begin
                    bfsq_we   = 1'b1;
                    bfsq_wa   = tail_reg[NODE_W-1:0];
                    bfsq_wd   = child_rdata_reg;
                    tail_next = CNT_W'(tail_reg + 1'b1);
                    v_next    = child_rdata_reg;
                    if (u_reg == '0)
                    begin
                        f_next     = '0;
                        state_next = S_B_F;
                    end
                    else
                    begin
                        gnode_next  = fu_reg;
                        gbuild_next = 1'b1;
                        state_next  = S_G_RD;
                    end
                end
            end

            S_B_F:
            begin
                nword_ra   = f_reg;
                swl_ra     = f_reg;
                state_next = S_B_WR;
            end

            S_B_WR:
            begin
                fail_we  = 1'b1;
                fail_wa  = v_reg;
                fail_wd  = f_reg;
                swl_we   = 1'b1;
                swl_wa   = v_reg;
                swl_wd   = (nword_rdata_reg != '0) ? f_reg : swl_rdata_reg;
                next_sym = 1'b1;
            end

            // Shared goto walk along failure links.
            S_G_RD:
            begin
                child_ra   = {gnode_reg, csym_reg};
                fail_ra    = gnode_reg;
                state_next = S_G_CHK;
            end

            S_G_CHK:
            begin
                if ((child_rdata_reg != '0) || (gnode_reg == '0))
                begin
                    if (gbuild_reg)
                    begin
                        f_next     = child_rdata_reg;
                        state_next = S_B_F;
                    end
                    else
                    begin
                        match_next = child_rdata_reg;
                        tnode_next = child_rdata_reg;
                        run_n_next = '0;
                        state_next = S_T_WALK;
                    end
                end
                else
                begin
                    gnode_next = fail_rdata_reg;
                    state_next = S_G_RD;
                end
            end

            // Walk the dictionary-suffix chain of the current node.
            S_T_WALK:
            begin
                if ((tnode_reg == '0) || (run_n_reg == RUN_W'(RESULT_CAP)))
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.match_start   = pend_start_reg;
                        result_next.match_end     = pos_reg;
                        result_next.pattern_id    = pend_id_reg;
                        result_next.last_of_run   = 1'b1;
                        result_next.overflow_seen = overflow_reg;
                        pend_valid_next           = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    nword_ra   = tnode_reg;
                    swl_ra     = tnode_reg;
                    state_next = S_T_W;
                end
            end

            S_T_W:
            begin
                tnext_next = swl_rdata_reg;
                if (nword_rdata_reg != '0)
                begin
                    w_minus    = WORD_W'(nword_rdata_reg - 1'b1);
                    wid_next   = w_minus[ID_W-1:0];
                    wlen_ra    = w_minus[ID_W-1:0];
                    state_next = S_T_L;
                end
                else
                begin
                    tnode_next = swl_rdata_reg;
                    state_next = S_T_WALK;
                end
            end

            // A word ends here; the previous one found is not the last.
            S_T_L:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next         = 1'b1;
                    result_next.match_start   = pend_start_reg;
                    result_next.match_end     = pos_reg;
                    result_next.pattern_id    = pend_id_reg;
                    result_next.last_of_run   = 1'b0;
                    result_next.overflow_seen = overflow_reg;
                end
                pend_valid_next = 1'b1;
                pend_start_next = POS_W'(pos_reg - POS_W'(wlen_rdata_reg) + 1'b1);
                pend_id_next    = wid_reg;
                run_n_next      = RUN_W'(run_n_reg + 1'b1);
                tnode_next      = tnext_reg;
                state_next      = S_T_WALK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance to the next symbol of the node being expanded.
        if (next_sym)
        begin
            if (csym_reg == SYM_W'(ALPHABET_SIZE - 1))
            begin
                state_next = S_B_POP;
            end
            else
            begin
                csym_next  = SYM_W'(csym_reg + 1'b1);
                state_next = S_B_CRD;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            node_count_reg   <= CNT_W'(1);
            word_count_reg   <= '0;
            cursor_reg       <= '0;
            ins_len_reg      <= '0;
            discard_reg      <= 1'b0;
            links_valid_reg  <= 1'b0;
            overflow_reg     <= 1'b0;
            match_reg        <= '0;
            text_pos_reg     <= '0;
            pos_reg          <= '0;
            last_reg         <= 1'b0;
            csym_reg         <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            u_reg            <= '0;
            fu_reg           <= '0;
            v_reg            <= '0;
            gnode_reg        <= '0;
            f_reg            <= '0;
            gbuild_reg       <= 1'b0;
            tnode_reg        <= '0;
            tnext_reg        <= '0;
            wid_reg          <= '0;
            run_n_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            pend_start_reg   <= '0;
            pend_id_reg      <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            node_count_reg   <= node_count_next;
            word_count_reg   <= word_count_next;
            cursor_reg       <= cursor_next;
            ins_len_reg      <= ins_len_next;
            discard_reg      <= discard_next;
            links_valid_reg  <= links_valid_next;
            overflow_reg     <= overflow_next;
            match_reg        <= match_next;
            text_pos_reg     <= text_pos_next;
            pos_reg          <= pos_next;
            last_reg         <= last_next;
            csym_reg         <= csym_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            u_reg            <= u_next;
            fu_reg           <= fu_next;
            v_reg            <= v_next;
            gnode_reg        <= gnode_next;
            f_reg            <= f_next;
            gbuild_reg       <= gbuild_next;
            tnode_reg        <= tnode_next;
            tnext_reg        <= tnext_next;
            wid_reg          <= wid_next;
            run_n_reg        <= run_n_next;
            pend_valid_reg   <= pend_valid_next;
            pend_start_reg   <= pend_start_next;
            pend_id_reg      <= pend_id_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_pattern_string_matcher.sv =====
// Aho-Corasick matcher. After reset the block sweeps its child table
// with busy high before it takes the first item. A two-entry queue holds
// accepted items; busy is high while it is full. A pattern byte reads
// the child table and then follows or creates the child, unless it is
// dropped by a limit. A build visits every alphabet slot of every node
// taken from the queue, and for each child finds its failure link,
// walking failure links where needed, and writes its links. A text byte
// only clears the match while links are stale; otherwise it walks failure
// links, then the dictionary-suffix chain, and reports the matches found.
// Each result appears with result_valid for exactly one cycle; the
// receiver must take it then, as results cannot be held off.
`default_nettype none

module multi_pattern_string_matcher (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire mpsm_pkg::in_item_t item,
    output logic                    result_valid,
    output mpsm_pkg::result_t       result
);
    import mpsm_pkg::*;

    back_status_t back_status;
    logic         cmd_valid;
    cmd_t         cmd;

    // Accept and classify items.
    mpsm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .back_status (back_status),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    // Execute trie updates, link builds and text steps.
    mpsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .status       (back_status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mpsm_checker.sv =====
`default_nettype none

module mpsm_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     busy,
    input wire                     result_valid,
    input wire mpsm_pkg::result_t  result
);
    import mpsm_pkg::*;

    logic        run_open_reg;
    logic        ovf_reg;
    logic [31:0] prev_start_reg;
    logic [31:0] prev_end_reg;

    // Track the open run of results for one text byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            prev_start_reg <= '0;
            prev_end_reg   <= '0;
        end
        else if (result_valid)
        begin
            run_open_reg   <= !result.last_of_run;
            ovf_reg        <= ovf_reg || result.overflow_seen;
            prev_start_reg <= result.match_start;
            prev_end_reg   <= result.match_end;
        end
    end

    // The table sweep keeps the block busy right after reset.
    a_busy_after_reset: assert property (@(posedge clk)
        (rst_n && !$past(rst_n)) |-> busy)
        else $error("block not busy right after reset");

    // A match is never longer than the longest pattern.
    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.match_end - result.match_start) < 32'd64))
        else $error("match span too long");

    // All results of one run end at the same text byte.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && run_open_reg) |-> (result.match_end == prev_end_reg))
        else $error("match end changed within a run");

    // Results of one run come longest first.
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && run_open_reg) |->
        (32'(result.match_end - result.match_start) <
         32'(prev_end_reg - prev_start_reg)))
        else $error("run not ordered longest first");

    // The overflow flag never clears once shown.
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ovf_reg) |-> result.overflow_seen)
        else $error("overflow flag cleared");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire
